>>> rtl/answering_machine_detect_fsm_assert.svh
// Assertion macros for the answering machine detector.
// Each use samples on clk and is off while arst_n is low.
`ifndef ANSWERING_MACHINE_DETECT_FSM_ASSERT_SVH
`define ANSWERING_MACHINE_DETECT_FSM_ASSERT_SVH

// Same-cycle implication.
`define AMD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AMD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/amd_pkg.sv
`timescale 1ns / 1ps

package amd_pkg;

	localparam logic [31:0] NO_VOICE_TIMEOUT_RST = 32'd2000;
	localparam logic [31:0] MACHINE_VOICE_RST    = 32'd1100;

	localparam int unsigned CFG_ADDR_W = 3;

	// register indexes
	localparam logic REG_NO_VOICE_TIMEOUT = 1'b0;
	localparam logic REG_MACHINE_VOICE    = 1'b1;

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_DETECT  = 3'd1,
		PH_HUMAN   = 3'd2,
		PH_MACHINE = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_SIL_BEGIN = 3'd1;
	localparam logic [2:0] EV_SIL       = 3'd2;
	localparam logic [2:0] EV_VOX_BEGIN = 3'd3;
	localparam logic [2:0] EV_VOX       = 3'd4;

	localparam logic [2:0] V_NO_VOICE    = 3'd0;
	localparam logic [2:0] V_MACH_VOICE  = 3'd1;
	localparam logic [2:0] V_MACH_SIL    = 3'd2;
	localparam logic [2:0] V_MACH_BEEP   = 3'd3;
	localparam logic [2:0] V_HUMAN_VOICE = 3'd4;
	localparam logic [2:0] V_HUMAN_SIL   = 3'd5;

	typedef struct packed {
		logic        func;
		logic [2:0]  vad_event;
		logic [31:0] event_time;
		logic [31:0] opposite_ms;
	} amd_item_t;

	typedef struct packed {
		logic       emit;
		logic [2:0] verdict;
		phase_t     phase;
	} amd_result_t;

endpackage

>>> rtl/amd_fsm.sv
`timescale 1ns / 1ps

module amd_fsm
	import amd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  amd_item_t   item,
	input  logic [31:0] no_voice_timeout_ms,
	input  logic [31:0] machine_voice_ms,
	output amd_result_t res
);

	phase_t      phase_q, phase_d;
	logic [31:0] start_q;
	logic        restart;
	logic        beep, sil, vox;
	logic [31:0] wait_ms, voice_ms;
	logic        timeout, long_voice;

	assign beep = item.func;
	assign sil  = !beep && (item.vad_event inside {EV_SIL_BEGIN, EV_SIL});
	assign vox  = !beep && (item.vad_event inside {EV_VOX_BEGIN, EV_VOX});

	assign wait_ms    = item.event_time - start_q;
	assign voice_ms   = wait_ms - item.opposite_ms;
	assign timeout    = wait_ms >= no_voice_timeout_ms;
	assign long_voice = voice_ms >= machine_voice_ms;

	// next state
	always_comb begin
		phase_d = phase_q;
		restart = 1'b0;
		case (phase_q)
			PH_WAIT: begin
				if (beep) begin
					phase_d = PH_MACHINE;
					restart = 1'b1;
				end else if (sil && timeout) begin
					phase_d = PH_DONE;
					restart = 1'b1;
				end else if (vox) begin
					phase_d = PH_DETECT;
					restart = 1'b1;
				end
			end
			PH_DETECT: begin
				if (beep) begin
					phase_d = PH_MACHINE;
					restart = 1'b1;
				end else if (sil) begin
					phase_d = PH_HUMAN;
					restart = 1'b1;
				end else if (vox && long_voice) begin
					phase_d = PH_MACHINE;
					restart = 1'b1;
				end
			end
			PH_HUMAN: begin
				if (beep) begin
					phase_d = PH_MACHINE;
					restart = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result
	always_comb begin
		res.emit    = 1'b0;
		res.verdict = V_NO_VOICE;
		res.phase   = phase_q;
		case (phase_q)
			PH_WAIT: begin
				if (beep) begin
					res.emit    = 1'b1;
					res.verdict = V_MACH_BEEP;
				end else if (sil && timeout) begin
					res.emit    = 1'b1;
					res.verdict = V_NO_VOICE;
				end
			end
			PH_DETECT: begin
				if (beep) begin
					res.emit    = 1'b1;
					res.verdict = V_MACH_BEEP;
				end else if (sil) begin
					res.emit    = 1'b1;
					res.verdict = V_HUMAN_SIL;
				end else if (vox && long_voice) begin
					res.emit    = 1'b1;
					res.verdict = V_MACH_VOICE;
				end
			end
			PH_HUMAN: begin
				if (beep) begin
					res.emit    = 1'b1;
					res.verdict = V_MACH_BEEP;
				end else if (item.vad_event == EV_SIL_BEGIN) begin
					res.emit    = 1'b1;
					res.verdict = V_HUMAN_SIL;
				end else if (item.vad_event == EV_VOX_BEGIN) begin
					res.emit    = 1'b1;
					res.verdict = V_HUMAN_VOICE;
				end
			end
			PH_MACHINE: begin
				if (!beep && item.vad_event == EV_SIL_BEGIN) begin
					res.emit    = 1'b1;
					res.verdict = V_MACH_SIL;
				end else if (!beep && item.vad_event == EV_VOX_BEGIN) begin
					res.emit    = 1'b1;
					res.verdict = V_MACH_VOICE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			start_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			if (restart) begin
				start_q <= item.event_time;
			end
		end
	end

endmodule

>>> rtl/answering_machine_detect_fsm.sv
`timescale 1ns / 1ps
// Answering machine detector: classifies a call from voice-activity and beep events.
// Input stream: one event per transaction; tuser is the beep flag, tdata carries
// vad_event, event_time and opposite_ms. Output stream: one verdict per classifying
// event; tuser is the verdict code, tdata the event time at which it was made.
// Events that classify nothing produce no output transaction.
// An event is registered in the input register, then evaluated against the phase
// state; its verdict is registered in the output register when the event advances.
// Throughput: one event per cycle while the output register is free or read, set by the
// phase update (two 32-bit subtractions and two compares feeding the phase register).
// An event waits in the input register while a verdict sits unclaimed in the
// output register; the input stalls only when both are full.
// APB registers: 0x0 no-voice timeout (ms), 0x4 machine voice limit (ms).
// Reset: phase returns to wait-for-voice, phase start time to zero, registers to
// 2000 and 1100 ms, both stream registers empty. Registers may be written only
// while the block is idle.

module answering_machine_detect_fsm
	import amd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [71:0]           s_axis_tdata,  // vad_event[2:0], event_time, opposite_ms
	input  logic                  s_axis_tuser,  // func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,  // verdict_time
	output logic [2:0]            m_axis_tuser,  // verdict
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic        v_s1;
	amd_item_t   item_s1;
	logic        adv;
	amd_result_t res;
	logic        out_v_q;
	logic [2:0]  out_verdict_q;
	logic [31:0] out_time_q;
	logic [31:0] no_voice_timeout_q;
	logic [31:0] machine_voice_q;
	logic        cfg_wr;

	assign adv           = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.func        <= s_axis_tuser;
			item_s1.vad_event   <= s_axis_tdata[2:0];
			item_s1.event_time  <= s_axis_tdata[34:3];
			item_s1.opposite_ms <= s_axis_tdata[66:35];
		end
	end

	amd_fsm u_fsm (
		.clk                 (clk),
		.arst_n              (arst_n),
		.adv                 (adv),
		.item                (item_s1),
		.no_voice_timeout_ms (no_voice_timeout_q),
		.machine_voice_ms    (machine_voice_q),
		.res                 (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			out_verdict_q <= res.verdict;
			out_time_q    <= item_s1.event_time;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_verdict_q;
	assign m_axis_tdata  = out_time_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_voice_timeout_q <= NO_VOICE_TIMEOUT_RST;
			machine_voice_q    <= MACHINE_VOICE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_NO_VOICE_TIMEOUT) begin
				no_voice_timeout_q <= pwdata;
			end else begin
				machine_voice_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == REG_MACHINE_VOICE) ? machine_voice_q : no_voice_timeout_q;

`include "answering_machine_detect_fsm_assert.svh"

	`AMD_ASSERT_NXT(a_emit_out, adv && res.emit, m_axis_tvalid && m_axis_tuser == $past(res.verdict), "verdict not presented")
	`AMD_ASSERT_IMP(a_rdy_empty, !v_s1, s_axis_tready, "input stalled while empty")
	`AMD_ASSERT_NXT(a_done_sticky, res.phase == PH_DONE, res.phase == PH_DONE, "left done phase")
	`AMD_ASSERT_IMP(a_verdict_rng, m_axis_tvalid, m_axis_tuser <= V_HUMAN_SIL, "bad verdict code")

endmodule
